// ===== src/thw_pkg.sv =====
// Shared types and constants for the task heartbeat watchdog.
// No dependencies; imported by every module of the block.
package thw_pkg;

  localparam int NUM_TASKS = 16;
  localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int MASK_W    = 16;

  // Request codes
  localparam logic [2:0] REQ_BEAT  = 3'd0;
  localparam logic [2:0] REQ_DELAY = 3'd1;
  localparam logic [2:0] REQ_SCAN  = 3'd2;
  localparam logic [2:0] REQ_LIMIT = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  task_req;
    logic [31:0] now_time;
    logic [31:0] prev_wake;
    logic [31:0] period;
    logic [31:0] limit_value;
  } thw_req_t;

  typedef struct packed {
    logic [15:0] timeout_mask;
    logic        task_valid;
    logic [31:0] wake_time;
    logic        missed;
    logic [31:0] last_beat;
    logic        task_timed_out;
    logic [31:0] timeouts_seen;
    logic [31:0] misses_seen;
  } thw_rsp_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch accepted request
    logic prep;       // precompute wake sums, clear scan index
    logic exec;       // table update: addressed entry, or all entries on clear
    logic scan_step;  // check one entry for timeout
    logic load_out;   // load result register
  } thw_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_scan;
    logic scan_last;
  } thw_sts_t;

endpackage

// ===== src/task_heartbeat_watchdog.sv =====
// Top level of the task heartbeat watchdog: sequencer plus datapath.
// Depends on thw_pkg, thw_ctrl and thw_dp.
//
// Watchdog for NUM_TASKS tasks. Each request (heartbeat, delay-until, scan,
// set-limit, clear-all) produces exactly one result carrying the timeout mask
// and the addressed task's state after the request. Requests are handled one
// at a time. A non-scan request holds the block from its acceptance to the
// earliest next acceptance (prep, update, result load, idle); a scan holds it
// through prep, the timeout compare visiting one task entry per cycle, result
// load and idle. A finished result sits in an output register, so a new
// request may be accepted while the previous result is still waiting; the
// block only stalls at result load if that register is still full. No
// clearing pass after reset.
module task_heartbeat_watchdog (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  thw_pkg::thw_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output thw_pkg::thw_rsp_t out_data
);
  import thw_pkg::*;

  thw_cmd_t cmd;
  thw_sts_t sts;

  // control: handshakes, step sequencing, result valid
  thw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: task tables, wake arithmetic, scan compare, result register
  thw_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== src/thw_ctrl.sv =====
// Sequencer for the task heartbeat watchdog: handshakes and step commands.
// Depends on thw_pkg.
module thw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  thw_pkg::thw_sts_t sts,
  output thw_pkg::thw_cmd_t cmd
);
  import thw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready      = (state_r == S_IDLE);
    cmd.capture   = in_ready && in_valid;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.is_scan ? S_SCAN : S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        // result register must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PREP))
    else $error("accepted request did not enter prep");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over undelivered result");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_valid_r && state_r == S_IDLE))
    else $error("loaded result not presented");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.scan_last) |=> (state_r == S_RESP))
    else $error("scan did not finish after last entry");

endmodule

// ===== src/thw_dp.sv =====
// Datapath for the task heartbeat watchdog: per-task tables, wake math,
// timeout check and result register. Depends on thw_pkg.
module thw_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  thw_pkg::thw_req_t in_data,
  input  thw_pkg::thw_cmd_t cmd,
  output thw_pkg::thw_sts_t sts,
  output thw_pkg::thw_rsp_t out_data
);
  import thw_pkg::*;

  thw_req_t              req_r;
  logic [31:0]           beat_r     [NUM_TASKS];
  logic [31:0]           exp_cnt_r  [NUM_TASKS];
  logic [31:0]           miss_cnt_r [NUM_TASKS];
  logic [31:0]           limit_r    [NUM_TASKS];
  logic [NUM_TASKS-1:0]  flag_r;
  logic [TASK_W-1:0]     scan_idx_r;
  logic [31:0]           wake_sum_r, now_sum_r, next_r;
  logic                  missed_r;
  thw_rsp_t              out_r;

  logic [TASK_W-1:0] t_idx, rd_idx;
  logic              task_ok;
  logic [31:0]       beat_rd, exp_rd, miss_rd, limit_rd, elapsed, diff;
  logic              flag_rd, hit, late, per_nz;

  assign t_idx   = req_r.task_req[TASK_W-1:0];
  assign task_ok = ({1'b0, req_r.task_req} < 6'(NUM_TASKS));
  assign rd_idx  = cmd.scan_step ? scan_idx_r : t_idx;

  assign beat_rd  = beat_r[rd_idx];
  assign exp_rd   = exp_cnt_r[rd_idx];
  assign miss_rd  = miss_cnt_r[rd_idx];
  assign limit_rd = limit_r[rd_idx];
  assign flag_rd  = flag_r[rd_idx];

  // scan: seen, enabled, and elapsed beyond limit
  assign elapsed = req_r.now_time - beat_rd;
  assign hit     = (beat_rd != 32'd0) && (limit_rd != 32'd0) && (elapsed > limit_rd);

  // delay-until: deadline passed when now - wake is non-negative
  assign diff   = req_r.now_time - wake_sum_r;
  assign late   = !diff[31];
  assign per_nz = (req_r.period != 32'd0);

  assign sts.is_scan   = (req_r.req_type == REQ_SCAN);
  assign sts.scan_last = (scan_idx_r == TASK_W'(NUM_TASKS - 1));

  // request capture and per-request scratch
  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_data;
    if (cmd.prep) begin
      wake_sum_r <= req_r.prev_wake + req_r.period;
      now_sum_r  <= req_r.now_time + req_r.period;
      next_r     <= req_r.prev_wake;
      missed_r   <= 1'b0;
    end
    if (cmd.exec && req_r.req_type == REQ_DELAY && per_nz) begin
      next_r   <= late ? now_sum_r : wake_sum_r;
      missed_r <= late;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.prep) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step && !sts.scan_last) begin
      scan_idx_r <= scan_idx_r + TASK_W'(1);
    end
  end

  // per-task tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        beat_r[i]     <= '0;
        exp_cnt_r[i]  <= '0;
        miss_cnt_r[i] <= '0;
        limit_r[i]    <= '0;
      end
    end else begin
      if (cmd.exec) begin
        unique case (req_r.req_type)
          REQ_BEAT: begin
            if (task_ok) begin
              beat_r[t_idx] <= req_r.now_time;
              flag_r[t_idx] <= 1'b0;
            end
          end
          REQ_DELAY: begin
            if (task_ok && per_nz) begin
              beat_r[t_idx] <= req_r.now_time;
              flag_r[t_idx] <= 1'b0;
              if (late) miss_cnt_r[t_idx] <= miss_rd + 32'd1;
            end
          end
          REQ_LIMIT: begin
            if (task_ok) limit_r[t_idx] <= req_r.limit_value;
          end
          REQ_CLEAR: begin
            flag_r <= '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
              beat_r[i]     <= '0;
              exp_cnt_r[i]  <= '0;
              miss_cnt_r[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_step && hit) begin
        flag_r[scan_idx_r] <= 1'b1;
        if (!flag_rd) exp_cnt_r[scan_idx_r] <= exp_rd + 32'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.timeout_mask   <= MASK_W'(flag_r);
      out_r.task_valid     <= task_ok;
      out_r.wake_time      <= next_r;
      out_r.missed         <= missed_r;
      out_r.last_beat      <= task_ok ? beat_rd : 32'd0;
      out_r.task_timed_out <= task_ok && flag_rd;
      out_r.timeouts_seen  <= task_ok ? exp_rd : 32'd0;
      out_r.misses_seen    <= task_ok ? miss_rd : 32'd0;
    end
  end

  assign out_data = out_r;

endmodule

// ===== tb/task_heartbeat_watchdog_tb.sv =====
// Self-checking testbench for task_heartbeat_watchdog: directed and random requests,
// with a predictor of the per-task watchdog state checked against every result.
// Depends on thw_pkg and the task_heartbeat_watchdog RTL.
`timescale 1ns / 100ps

module task_heartbeat_watchdog_tb;
  import thw_pkg::*;

  // Request codes the block decodes as no-ops
  localparam logic [2:0] REQ_SPARE5 = 3'd5;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  localparam int RANDOM_REQS = 1375;
  localparam int DRAIN_CYCLES = 40;   // well past the length of a scan
  localparam int MAX_PRINTS = 40;
  localparam int STEADY_FROM = 500;   // window with no idling on either side
  localparam int STEADY_TO = 750;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  thw_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  thw_rsp_t out_data;

  task_heartbeat_watchdog i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted watchdog state, one entry per task
  // ---------------------------------------------------------------------------
  logic [31:0] beat_ms      [NUM_TASKS];  // 0 reads as never seen
  logic        expired      [NUM_TASKS];
  logic [31:0] expiry_tally [NUM_TASKS];
  logic [31:0] miss_tally   [NUM_TASKS];
  logic [31:0] limit_ms     [NUM_TASKS];  // 0 disables the task

  thw_req_t pending_reqs[$];    // requests not yet driven
  thw_rsp_t predicted_rsps[$];  // results owed by the block, oldest first

  int accepted_count = 0;
  int error_count = 0;
  logic steady;
  thw_rsp_t want_rsp;

  assign steady = (accepted_count >= STEADY_FROM) && (accepted_count < STEADY_TO);

  initial begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      beat_ms[i] = '0;
      expired[i] = 1'b0;
      expiry_tally[i] = '0;
      miss_tally[i] = '0;
      limit_ms[i] = '0;
    end
  end

  // Applies one request to the predicted state and returns the result it owes.
  function automatic thw_rsp_t track_request(input thw_req_t r);
    thw_rsp_t    rsp;
    logic        in_range;
    int          idx;
    logic [31:0] due;
    logic [31:0] lateness;
    logic [31:0] elapsed;
    rsp = '0;
    in_range = (r.task_req < NUM_TASKS);
    idx = in_range ? int'(r.task_req) : 0;
    rsp.wake_time = r.prev_wake;
    case (r.req_type)
      REQ_BEAT: begin
        if (in_range) begin
          beat_ms[idx] = r.now_time;
          expired[idx] = 1'b0;
        end
      end
      REQ_DELAY: begin
        // zero period leaves everything alone, heartbeat included
        if (r.period != '0) begin
          if (in_range) begin
            beat_ms[idx] = r.now_time;
            expired[idx] = 1'b0;
          end
          due = r.prev_wake + r.period;
          lateness = r.now_time - due;
          rsp.wake_time = due;
          // deadline reached or passed: reschedule from now
          if (!lateness[31]) begin
            rsp.wake_time = r.now_time + r.period;
            rsp.missed = 1'b1;
            if (in_range) miss_tally[idx] = miss_tally[idx] + 1;
          end
        end
      end
      REQ_SCAN: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          elapsed = r.now_time - beat_ms[i];
          if (beat_ms[i] != '0 && limit_ms[i] != '0 && elapsed > limit_ms[i]) begin
            if (!expired[i]) expiry_tally[i] = expiry_tally[i] + 1;
            expired[i] = 1'b1;
          end
        end
      end
      REQ_LIMIT: begin
        if (in_range) limit_ms[idx] = r.limit_value;
      end
      REQ_CLEAR: begin
        // limits survive a clear
        for (int i = 0; i < NUM_TASKS; i++) begin
          beat_ms[i] = '0;
          expired[i] = 1'b0;
          expiry_tally[i] = '0;
          miss_tally[i] = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_TASKS && i < MASK_W; i++)
      rsp.timeout_mask[i] = expired[i];
    rsp.task_valid = in_range;
    if (in_range) begin
      rsp.last_beat = beat_ms[idx];
      rsp.task_timed_out = expired[idx];
      rsp.timeouts_seen = expiry_tally[idx];
      rsp.misses_seen = miss_tally[idx];
    end
    return rsp;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("%0t ns  MISMATCH  %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  task automatic push_req(input logic [2:0] kind, input logic [4:0] idx,
                          input logic [31:0] now, input logic [31:0] prev,
                          input logic [31:0] per, input logic [31:0] lim);
    thw_req_t r;
    r.req_type = kind;
    r.task_req = idx;
    r.now_time = now;
    r.prev_wake = prev;
    r.period = per;
    r.limit_value = lim;
    pending_reqs.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents pending requests, idling at random outside the steady
  // window. The prediction is taken at the edge where the request is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_rsps.push_back(track_request(in_data));
        accepted_count <= accepted_count + 1;
      end
      // slot is free unless a request is still waiting on ready
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction,
  // stalling the result side at random outside the steady window.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_rsps.size() == 0) begin
          flag_mismatch("result arrived with no request outstanding");
        end else begin
          want_rsp = predicted_rsps.pop_front();
          check_field("timeout_mask", 32'(out_data.timeout_mask), 32'(want_rsp.timeout_mask));
          check_field("task_valid", 32'(out_data.task_valid), 32'(want_rsp.task_valid));
          check_field("wake_time", out_data.wake_time, want_rsp.wake_time);
          check_field("missed", 32'(out_data.missed), 32'(want_rsp.missed));
          check_field("last_beat", out_data.last_beat, want_rsp.last_beat);
          check_field("task_timed_out", 32'(out_data.task_timed_out),
                      32'(want_rsp.task_timed_out));
          check_field("timeouts_seen", out_data.timeouts_seen, want_rsp.timeouts_seen);
          check_field("misses_seen", out_data.misses_seen, want_rsp.misses_seen);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] wall_ms;
    logic [31:0] per;
    logic [31:0] off;
    logic [4:0]  tsk;
    int          pick;

    // Directed: limits at the extremes and out of range
    push_req(REQ_SCAN, 5'd0, 32'd50, $urandom(), $urandom(), $urandom());
    push_req(REQ_LIMIT, 5'd0, $urandom(), $urandom(), $urandom(), 32'd100);
    push_req(REQ_LIMIT, 5'(NUM_TASKS - 1), $urandom(), $urandom(), $urandom(), '1);
    push_req(REQ_LIMIT, 5'd1, $urandom(), $urandom(), $urandom(), 32'd1);
    push_req(REQ_LIMIT, 5'(NUM_TASKS), $urandom(), $urandom(), $urandom(), 32'd5);
    push_req(REQ_LIMIT, '1, $urandom(), $urandom(), $urandom(), 32'd7);
    // heartbeats, one at time zero that scans must skip
    push_req(REQ_BEAT, 5'd0, 32'd1000, $urandom(), $urandom(), $urandom());
    push_req(REQ_BEAT, 5'(NUM_TASKS - 1), '1, $urandom(), $urandom(), $urandom());
    push_req(REQ_BEAT, 5'd1, 32'd0, $urandom(), $urandom(), $urandom());
    push_req(REQ_BEAT, '1, 32'd1000, $urandom(), $urandom(), $urandom());
    // elapsed equal to limit, then one past it, then no recount
    push_req(REQ_SCAN, 5'd0, 32'd1100, $urandom(), $urandom(), $urandom());
    push_req(REQ_SCAN, 5'd0, 32'd1101, $urandom(), $urandom(), $urandom());
    push_req(REQ_SCAN, 5'd0, 32'd1300, $urandom(), $urandom(), $urandom());
    push_req(REQ_BEAT, 5'd0, 32'd1300, $urandom(), $urandom(), $urandom());
    // delay-until: zero period, late, early, exactly due, out of range, wrap
    push_req(REQ_DELAY, 5'd0, 32'd2000, 32'd1500, 32'd0, $urandom());
    push_req(REQ_DELAY, 5'd0, 32'd2000, 32'd1500, 32'd100, $urandom());
    push_req(REQ_DELAY, 5'd2, 32'd2000, 32'd1950, 32'd100, $urandom());
    push_req(REQ_DELAY, 5'd3, 32'd2000, 32'd1900, 32'd100, $urandom());
    push_req(REQ_DELAY, 5'd20, 32'd2000, 32'd0, 32'd5, $urandom());
    push_req(REQ_DELAY, 5'd4, 32'd5, 32'hFFFF_FFF0, '1, $urandom());
    push_req(REQ_DELAY, 5'd5, 32'h8000_0001, 32'd0, 32'd1, $urandom());
    // unused codes, then clear all
    push_req(REQ_SPARE5, 5'd0, $urandom(), $urandom(), $urandom(), $urandom());
    push_req(REQ_SPARE6, 5'd0, $urandom(), $urandom(), $urandom(), $urandom());
    push_req(REQ_SPARE7, 5'd0, $urandom(), $urandom(), $urandom(), $urandom());
    push_req(REQ_CLEAR, 5'd0, $urandom(), $urandom(), $urandom(), $urandom());
    push_req(REQ_SCAN, 5'd0, 32'd2000000, $urandom(), $urandom(), $urandom());

    // Random: mostly coherent traffic on a moving wall clock, some noise
    wall_ms = $urandom_range(1000, 1);
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if ($urandom_range(99) < 10) begin
        push_req(3'($urandom_range(REQ_SPARE7)), 5'($urandom_range(31)), $urandom(),
                 $urandom(), $urandom(), $urandom());
      end else begin
        wall_ms = wall_ms + $urandom_range(120);
        if ($urandom_range(99) == 0) wall_ms = wall_ms + $urandom();  // big jump, may wrap
        tsk = ($urandom_range(99) < 8) ? 5'($urandom_range(31, NUM_TASKS))
                                       : 5'($urandom_range(NUM_TASKS - 1));
        pick = $urandom_range(99);
        if (pick < 30) begin
          push_req(REQ_BEAT, tsk, wall_ms, $urandom(), $urandom(), $urandom());
        end else if (pick < 55) begin
          per = ($urandom_range(99) < 5) ? 32'd0 : 32'($urandom_range(200, 1));
          off = 32'($urandom_range(200)) - 32'd100;  // deadline around now
          push_req(REQ_DELAY, tsk, wall_ms, wall_ms + off - per, per, $urandom());
        end else if (pick < 85) begin
          push_req(REQ_SCAN, tsk, wall_ms, $urandom(), $urandom(), $urandom());
        end else if (pick < 98) begin
          pick = $urandom_range(99);
          push_req(REQ_LIMIT, tsk, $urandom(), $urandom(), $urandom(),
                   (pick < 8) ? 32'd0 : (pick < 14) ? $urandom() : 32'($urandom_range(400, 1)));
        end else begin
          push_req(REQ_CLEAR, tsk, $urandom(), $urandom(), $urandom(), $urandom());
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (predicted_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("task_heartbeat_watchdog_tb: clean");
    end else begin
      $display("task_heartbeat_watchdog_tb: errors");
    end
    $finish;
  end

  // Watchdog on the run itself: normal runs finish well inside this
  initial begin
    #4_000_000;
    $display("task_heartbeat_watchdog_tb: errors");
    $finish;
  end

endmodule
